### hw/rtl/integer_to_radix_text_macros.svh
// Assertion macros for the integer to radix text block.
// Included by the RTL files that check their own logic; needs no package.
// Each macro becomes empty when SYNTHESIS is defined.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

`ifndef SYNTHESIS

`define ITRT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ITRT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ITRT_ASSERT(lbl, clk, rst_n, prop, msg)

`define ITRT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/itrt_pkg.sv
// Shared constants, types and helper functions of the integer to radix text block.
// Used by the interfaces, the divider and the top level; depends on nothing.
package itrt_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RADIX_W         = 6;
	localparam int CHAR_W          = 8;
	localparam int LEN_W           = 6;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic               done;
		logic [RADIX_W-1:0] rem;
	} div_status_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > DIGIT_MAX_DEC) begin
			res = CHAR_A + CHAR_W'(d - RADIX_DEC);
		end else begin
			res = CHAR_ZERO + CHAR_W'(d);
		end
		return res;
	endfunction

endpackage

### hw/rtl/itrt_if.sv
// Valid/ready channel interfaces for the integer to radix text block.
// Input word carries the integer, output word one character; uses itrt_pkg.
interface itrt_in_if #(
	parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itrt_out_if;
	logic                         valid;
	logic                         ready;
	logic [itrt_pkg::CHAR_W-1:0]  out_char;
	logic                         is_last;
	logic [itrt_pkg::LEN_W-1:0]   text_length;

	modport source (output valid, output out_char, output is_last, output text_length,
		input ready);
	modport sink   (input valid, input out_char, input is_last, input text_length,
		output ready);
endinterface

### hw/rtl/itrt_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on itrt_pkg and the assertion macro header.
`include "integer_to_radix_text_macros.svh"

module itrt_divider #(
	parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_WIDTH-1:0]        dividend,
	input  logic [itrt_pkg::RADIX_W-1:0]  base,
	output logic [VALUE_WIDTH-1:0]        quotient,
	output itrt_pkg::div_status_t         status
);
	import itrt_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] dq_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     base_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [RADIX_W:0]       trial;
	logic [RADIX_W:0]       diff;
	logic                   qbit;
	logic [RADIX_W-1:0]     rem_nxt;

	always_comb begin
		trial   = {rem_q, dq_q[VALUE_WIDTH-1]};
		diff    = trial - {1'b0, base_q};
		qbit    = (trial >= {1'b0, base_q});
		rem_nxt = qbit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(VALUE_WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= dividend;
			rem_q  <= '0;
			base_q <= base;
		end else if (busy_q) begin
			dq_q  <= {dq_q[VALUE_WIDTH-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	assign quotient    = dq_q;
	assign status.done = done_q;
	assign status.rem  = rem_q;

	`ITRT_ASSERT(a_rem_below_base, clk, arst_n, done_q |-> (rem_q < base_q), "remainder not below base")
	`ITRT_ASSERT_NEVER(a_done_while_busy, clk, arst_n, done_q && busy_q, "done while busy")

endmodule

### hw/rtl/integer_to_radix_text.sv
// Integer to radix text: converts one integer word into a stream of ASCII character words.
// Uses itrt_pkg, itrt_in_if, itrt_out_if, itrt_divider and the assertion macro header.
//
// Usage: din takes one two's complement integer per word (valid/ready). dout gives one
// character per word, most significant first, with is_last on the final character and
// text_length (sign included) on every character. cfg_we/cfg_wdata write the radix
// (2..36, values outside are clamped); write it only while the block is idle. Radix ten
// prints a leading '-' for negative values; other radices print the unsigned pattern.
// Each digit comes from one pass of the bit-serial divider; each character is read back
// from the digit memory and registered on dout, with the '-' sign sent first. One item is
// converted at a time; din is ready only between items, while the final character may
// still wait on dout.
// Digits are kept in a VALUE_WIDTH-entry memory and read back in reverse order.
// Reset clears the control state and sets the radix to ten. A stall on dout holds the
// output word and pauses the read-back; nothing is dropped.
`include "integer_to_radix_text_macros.svh"

module integer_to_radix_text #(
	parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	itrt_in_if.sink                       din,
	itrt_out_if.source                    dout,
	input  logic                          cfg_we,
	input  logic [itrt_pkg::RADIX_W-1:0]  cfg_wdata
);
	import itrt_pkg::*;

	localparam int AW = $clog2(VALUE_WIDTH);
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_LD   = 3'd4;

	logic [2:0]             state_q;
	logic [RADIX_W-1:0]     radix_q;
	logic                   neg_q;
	logic [CW-1:0]          ndig_q;
	logic [AW-1:0]          ptr_q;
	logic [LEN_W-1:0]       len_q;
	logic [RADIX_W-1:0]     mem [VALUE_WIDTH];
	logic [RADIX_W-1:0]     rd_data_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic                   out_last_q;
	logic [LEN_W-1:0]       out_len_q;

	logic [RADIX_W-1:0]     base_eff;
	logic                   accept;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] quotient;
	div_status_t            status;
	logic                   digit_wr;
	logic                   more_digits;
	logic                   out_free;
	logic                   out_load;
	logic [CW:0]            len_sum;
	logic                   char_ok;

	always_comb begin
		base_eff     = clamp_radix(radix_q);
		accept       = din.valid && din.ready;
		neg_in       = (base_eff == RADIX_DEC) && din.value[VALUE_WIDTH-1];
		mag_in       = neg_in ? (~din.value + VALUE_WIDTH'(1)) : din.value;
		digit_wr     = (state_q == ST_DIV) && status.done;
		more_digits  = (quotient != '0);
		div_start    = accept || (digit_wr && more_digits);
		div_dividend = accept ? mag_in : quotient;
		out_free     = !out_valid_q || dout.ready;
		out_load     = out_free && ((state_q == ST_SIGN) || (state_q == ST_LD));
		len_sum      = {1'b0, ndig_q} + (CW+1)'(1) + (CW+1)'(neg_q);
		char_ok      = (out_char_q == CHAR_MINUS) ||
			((out_char_q >= CHAR_ZERO) && (out_char_q <= CHAR_NINE)) ||
			((out_char_q >= CHAR_A) && (out_char_q <= CHAR_Z));
	end

	assign din.ready = (state_q == ST_IDLE);

	itrt_divider #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.base     (base_eff),
		.quotient (quotient),
		.status   (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) radix_q <= cfg_wdata;
			out_valid_q <= out_load || (out_valid_q && !dout.ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (digit_wr && !more_digits) state_q <= neg_q ? ST_SIGN : ST_RD;
				end
				ST_SIGN: begin
					if (out_free) state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (out_free) state_q <= (ptr_q == '0) ? ST_IDLE : ST_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= neg_in;
			ndig_q <= '0;
		end
		if (digit_wr) begin
			mem[ndig_q[AW-1:0]] <= status.rem;
			ndig_q              <= ndig_q + CW'(1);
			if (!more_digits) begin
				ptr_q <= ndig_q[AW-1:0];
				len_q <= LEN_W'(len_sum);
			end
		end
		rd_data_q <= mem[ptr_q];
		if (state_q == ST_SIGN && out_free) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
			out_len_q  <= len_q;
		end
		if (state_q == ST_LD && out_free) begin
			out_char_q <= digit_char(rd_data_q);
			out_last_q <= (ptr_q == '0);
			out_len_q  <= len_q;
			if (ptr_q != '0) ptr_q <= ptr_q - AW'(1);
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.out_char    = out_char_q;
	assign dout.is_last     = out_last_q;
	assign dout.text_length = out_len_q;

	`ITRT_ASSERT(a_accept_starts_div, clk, arst_n, accept |=> (state_q == ST_DIV), "no division after accept")
	`ITRT_ASSERT(a_char_legal, clk, arst_n, out_valid_q |-> char_ok, "illegal character")
	`ITRT_ASSERT_NEVER(a_len_zero, clk, arst_n, out_valid_q && (out_len_q == '0), "zero text length")
	`ITRT_ASSERT(a_stall_holds, clk, arst_n, (out_valid_q && !dout.ready) |=> (out_valid_q && $stable(out_char_q)), "stalled word changed")

endmodule
